// ===== rtl/source_text_lexer_top_macros.svh =====
// ============================================================================
// source_text_lexer_top_macros.svh
// Assertion shorthands shared by the lexer checkers.
// ============================================================================
`ifndef SOURCE_TEXT_LEXER_TOP_MACROS_SVH
`define SOURCE_TEXT_LEXER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define STL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define STL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/stl_pkg.sv =====
// ============================================================================
// stl_pkg
// Shared types, constants and helper functions of the source text lexer.
// ============================================================================
package stl_pkg;

    localparam int POS_W = 16;
    localparam int TOKW  = 16;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    localparam int GROUP_MAX   = 3;
    localparam int GROUP_CNT_W = 2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;

    typedef enum logic [4:0] {
        KIND_NUMBER = 5'd0,
        KIND_IDENT  = 5'd1,
        KIND_IF     = 5'd2,
        KIND_ELSE   = 5'd3,
        KIND_FALSE  = 5'd4,
        KIND_TRUE   = 5'd5,
        KIND_FOR    = 5'd6,
        KIND_RETURN = 5'd7,
        KIND_WHILE  = 5'd8,
        KIND_LPAREN = 5'd9,
        KIND_RPAREN = 5'd10,
        KIND_LBRACE = 5'd11,
        KIND_RBRACE = 5'd12,
        KIND_COMMA  = 5'd13,
        KIND_DOT    = 5'd14,
        KIND_MINUS  = 5'd15,
        KIND_PLUS   = 5'd16,
        KIND_SEMI   = 5'd17,
        KIND_STAR   = 5'd18,
        KIND_SLASH  = 5'd19,
        KIND_NOT    = 5'd20,
        KIND_NE     = 5'd21,
        KIND_ASSIGN = 5'd22,
        KIND_EQ     = 5'd23,
        KIND_LT     = 5'd24,
        KIND_LE     = 5'd25,
        KIND_GT     = 5'd26,
        KIND_GE     = 5'd27,
        KIND_ERROR  = 5'd28,
        KIND_END    = 5'd29
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [TOKW-1:0]  start;
        logic [TOKW-1:0]  len;
    } token_t;

    typedef struct packed {
        logic [GROUP_CNT_W-1:0]  count;
        token_t [GROUP_MAX-1:0]  tok;
    } group_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef struct packed {
        logic  hit;
        kind_t kind;
    } punct_hit_t;

    function automatic logic [POS_W-1:0] sat_inc(logic [POS_W-1:0] v);
        return (v == POS_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [TOKW-1:0] to_field(logic [POS_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[TOKW-1:0];
    endfunction

    function automatic kind_t ident_kind(logic [47:0] w, logic [POS_W-1:0] len);
        kind_t k;
        k = KIND_IDENT;
        if (len == POS_W'(2) && w[15:0] == 16'h6966)
            k = KIND_IF;
        if (len == POS_W'(3) && w[23:0] == 24'h666F72)
            k = KIND_FOR;
        if (len == POS_W'(4) && w[31:0] == 32'h656C7365)
            k = KIND_ELSE;
        if (len == POS_W'(4) && w[31:0] == 32'h74727565)
            k = KIND_TRUE;
        if (len == POS_W'(5) && w[39:0] == 40'h66616C7365)
            k = KIND_FALSE;
        if (len == POS_W'(5) && w[39:0] == 40'h7768696C65)
            k = KIND_WHILE;
        if (len == POS_W'(6) && w[47:0] == 48'h72657475726E)
            k = KIND_RETURN;
        return k;
    endfunction

    function automatic punct_hit_t punct_lookup(logic [7:0] c);
        punct_hit_t r;
        r.hit  = 1'b1;
        r.kind = KIND_ERROR;
        case (c)
            8'h28:   r.kind = KIND_LPAREN;
            8'h29:   r.kind = KIND_RPAREN;
            8'h7B:   r.kind = KIND_LBRACE;
            8'h7D:   r.kind = KIND_RBRACE;
            8'h2C:   r.kind = KIND_COMMA;
            8'h2E:   r.kind = KIND_DOT;
            8'h2D:   r.kind = KIND_MINUS;
            8'h2B:   r.kind = KIND_PLUS;
            8'h3B:   r.kind = KIND_SEMI;
            8'h2A:   r.kind = KIND_STAR;
            8'h2F:   r.kind = KIND_SLASH;
            default: r.hit  = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/stl_fifo.sv =====
// ============================================================================
// stl_fifo
// Short queue of token groups between the scanner and the output serializer.
// ============================================================================
module stl_fifo
    import stl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  group_t     wdata,
    input  logic       pop,
    output group_t     rdata,
    output fifo_stat_t stat
);

    group_t                entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] cnt_reg;
    logic [FIFO_CNT_W-1:0] cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata      = entry_reg[rd_ptr_reg];
    assign stat.full  = (cnt_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign stat.empty = (cnt_reg == '0);

endmodule

// ===== rtl/stl_front.sv =====
// ============================================================================
// stl_front
// Byte scanner: classifies each beat, tracks the pending token and builds
// the group of finished tokens that the beat causes.
// ============================================================================
module stl_front
    import stl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] source_byte,
    input  logic       end_of_source,
    input  fifo_stat_t stat,
    output logic       push,
    output group_t     group
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_NUMBER,
        MODE_IDENT,
        MODE_OPER
    } mode_t;

    typedef enum logic [1:0] {
        OP_NOT,
        OP_ASSIGN,
        OP_LT,
        OP_GT
    } oper_t;

    function automatic kind_t op_single(oper_t op);
        kind_t k;
        case (op)
            OP_NOT:    k = KIND_NOT;
            OP_ASSIGN: k = KIND_ASSIGN;
            OP_LT:     k = KIND_LT;
            OP_GT:     k = KIND_GT;
            default:   k = KIND_NOT;
        endcase
        return k;
    endfunction

    function automatic kind_t op_with_eq(oper_t op);
        kind_t k;
        case (op)
            OP_NOT:    k = KIND_NE;
            OP_ASSIGN: k = KIND_EQ;
            OP_LT:     k = KIND_LE;
            OP_GT:     k = KIND_GE;
            default:   k = KIND_NE;
        endcase
        return k;
    endfunction

    mode_t            mode_reg;
    mode_t            mode_next;
    oper_t            op_reg;
    oper_t            op_next;
    logic [POS_W-1:0] start_reg;
    logic [POS_W-1:0] start_next;
    logic [POS_W-1:0] len_reg;
    logic [POS_W-1:0] len_next;
    logic [47:0]      kwin_reg;
    logic [47:0]      kwin_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;

    logic             accept;
    logic             is_digit;
    logic             is_alpha;
    logic             is_space;
    logic             is_oper;
    oper_t            oper_code;
    punct_hit_t       punct;
    logic             consumed;

    logic             a_vld;
    kind_t            a_kind;
    logic [POS_W-1:0] a_len;
    logic             b_vld;
    kind_t            b_kind;
    logic             c_vld;
    kind_t            c_kind;
    logic [POS_W-1:0] c_len;
    token_t           tok_a;
    token_t           tok_bc;
    token_t           tok_d;
    logic             bc_vld;

    assign in_ready = !stat.full;
    assign accept   = in_valid && in_ready;

    assign is_digit = (source_byte >= CH_0) && (source_byte <= CH_9);
    assign is_alpha = ((source_byte >= CH_LC_A) && (source_byte <= CH_LC_Z))
                   || ((source_byte >= CH_UC_A) && (source_byte <= CH_UC_Z))
                   || (source_byte == CH_UNDER);
    assign is_space = (source_byte == CH_SPACE) || (source_byte == CH_NL);
    assign punct    = punct_lookup(source_byte);

    always_comb
    begin
        is_oper   = 1'b1;
        oper_code = OP_NOT;
        case (source_byte)
            CH_BANG: oper_code = OP_NOT;
            CH_EQ:   oper_code = OP_ASSIGN;
            CH_LT:   oper_code = OP_LT;
            CH_GT:   oper_code = OP_GT;
            default: is_oper   = 1'b0;
        endcase
    end

    // close or extend the pending token, then open a new one
    always_comb
    begin
        mode_next  = mode_reg;
        op_next    = op_reg;
        start_next = start_reg;
        len_next   = len_reg;
        kwin_next  = kwin_reg;
        consumed   = 1'b0;
        a_vld      = 1'b0;
        a_kind     = KIND_NUMBER;
        a_len      = len_reg;
        b_vld      = 1'b0;
        b_kind     = KIND_ERROR;

        case (mode_reg)
            MODE_OPER:
            begin
                a_vld     = 1'b1;
                mode_next = MODE_IDLE;
                if (source_byte == CH_EQ)
                begin
                    a_kind   = op_with_eq(op_reg);
                    a_len    = POS_W'(2);
                    consumed = 1'b1;
                end
                else
                begin
                    a_kind = op_single(op_reg);
                    a_len  = POS_W'(1);
                end
            end
            MODE_NUMBER:
            begin
                if (is_digit)
                begin
                    len_next = sat_inc(len_reg);
                    consumed = 1'b1;
                end
                else
                begin
                    a_vld     = 1'b1;
                    a_kind    = KIND_NUMBER;
                    mode_next = MODE_IDLE;
                end
            end
            MODE_IDENT:
            begin
                if (is_alpha)
                begin
                    len_next  = sat_inc(len_reg);
                    kwin_next = {kwin_reg[39:0], source_byte};
                    consumed  = 1'b1;
                end
                else
                begin
                    a_vld     = 1'b1;
                    a_kind    = ident_kind(kwin_reg, len_reg);
                    mode_next = MODE_IDLE;
                end
            end
            default:
            begin
            end
        endcase

        if (!consumed)
        begin
            if (is_digit)
            begin
                mode_next  = MODE_NUMBER;
                start_next = pos_reg;
                len_next   = POS_W'(1);
            end
            else if (is_alpha)
            begin
                mode_next  = MODE_IDENT;
                start_next = pos_reg;
                len_next   = POS_W'(1);
                kwin_next  = {40'b0, source_byte};
            end
            else if (is_space)
            begin
            end
            else if (punct.hit)
            begin
                b_vld  = 1'b1;
                b_kind = punct.kind;
            end
            else if (is_oper)
            begin
                mode_next  = MODE_OPER;
                op_next    = oper_code;
                start_next = pos_reg;
                len_next   = POS_W'(1);
            end
            else
            begin
                b_vld = 1'b1;
            end
        end

        pos_next = sat_inc(pos_reg);
    end

    // flush of the pending token on the final beat
    always_comb
    begin
        c_vld  = (mode_next != MODE_IDLE);
        c_kind = KIND_NUMBER;
        c_len  = len_next;
        case (mode_next)
            MODE_IDENT:
            begin
                c_kind = ident_kind(kwin_next, len_next);
            end
            MODE_OPER:
            begin
                c_kind = op_single(op_next);
                c_len  = POS_W'(1);
            end
            default:
            begin
                c_kind = KIND_NUMBER;
            end
        endcase
    end

    // pack the tokens of this beat, in order, into one group
    always_comb
    begin
        tok_a.kind  = a_kind;
        tok_a.start = to_field(start_reg);
        tok_a.len   = to_field(a_len);

        tok_d.kind  = KIND_END;
        tok_d.start = to_field(pos_next);
        tok_d.len   = '0;

        bc_vld = b_vld || (end_of_source && c_vld);
        if (b_vld)
        begin
            tok_bc.kind  = b_kind;
            tok_bc.start = to_field(pos_reg);
            tok_bc.len   = to_field(POS_W'(1));
        end
        else
        begin
            tok_bc.kind  = c_kind;
            tok_bc.start = to_field(start_next);
            tok_bc.len   = to_field(c_len);
        end

        group.count = GROUP_CNT_W'(a_vld) + GROUP_CNT_W'(bc_vld)
                    + GROUP_CNT_W'(end_of_source);
        group.tok[2] = tok_d;
        if (a_vld)
        begin
            group.tok[0] = tok_a;
            group.tok[1] = bc_vld ? tok_bc : tok_d;
        end
        else if (bc_vld)
        begin
            group.tok[0] = tok_bc;
            group.tok[1] = tok_d;
        end
        else
        begin
            group.tok[0] = tok_d;
            group.tok[1] = tok_d;
        end
    end

    assign push = accept && (group.count != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            op_reg    <= OP_NOT;
            start_reg <= '0;
            len_reg   <= '0;
            kwin_reg  <= '0;
            pos_reg   <= '0;
        end
        else if (accept)
        begin
            if (end_of_source)
            begin
                mode_reg  <= MODE_IDLE;
                op_reg    <= OP_NOT;
                start_reg <= '0;
                len_reg   <= '0;
                kwin_reg  <= '0;
                pos_reg   <= '0;
            end
            else
            begin
                mode_reg  <= mode_next;
                op_reg    <= op_next;
                start_reg <= start_next;
                len_reg   <= len_next;
                kwin_reg  <= kwin_next;
                pos_reg   <= pos_next;
            end
        end
    end

endmodule

// ===== rtl/stl_back.sv =====
// ============================================================================
// stl_back
// Output serializer: walks the head group one token per beat and pops it
// after its last token is taken.
// ============================================================================
module stl_back
    import stl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  fifo_stat_t        stat,
    input  group_t            head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [4:0]        token_kind,
    output logic [TOKW-1:0]   token_start,
    output logic [TOKW-1:0]   token_length,
    output logic              last_of_run
);

    logic [GROUP_CNT_W-1:0] idx_reg;
    logic [GROUP_CNT_W-1:0] idx_next;
    logic                   fire;
    token_t                 cur;

    assign out_valid    = !stat.empty;
    assign cur          = head.tok[idx_reg];
    assign token_kind   = cur.kind;
    assign token_start  = cur.start;
    assign token_length = cur.len;
    assign last_of_run  = (idx_reg == (head.count - 1'b1));

    assign fire = out_valid && out_ready;
    assign pop  = fire && last_of_run;

    always_comb
    begin
        idx_next = idx_reg;
        if (pop)
        begin
            idx_next = '0;
        end
        else if (fire)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

// ===== rtl/source_text_lexer_top.sv =====
// ============================================================================
// source_text_lexer_top
// Streaming lexical scanner: source bytes in, tokens (kind, start, length)
// out, with a group queue between the scanner and the output serializer.
// ============================================================================
//   channel | beat                              | handshake
//   --------+-----------------------------------+---------------------
//   in      | source_byte, end_of_source        | in_valid / in_ready
//   out     | token_kind, token_start,          | out_valid / out_ready
//           | token_length, last_of_run         |
//
// The scanner takes one byte per cycle while in_ready is high; a byte's tokens
// reach the output no earlier than the next cycle, one token per cycle while out_ready is high.
// A byte causes 0 to 3 tokens, which leave the output one per beat.
// in_ready drops only while the four-group queue is full.
// rst_n clears all control state at once; no clearing pass.
// ============================================================================
module source_text_lexer_top
    import stl_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      source_byte,
    input  logic            end_of_source,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [4:0]      token_kind,
    output logic [TOKW-1:0] token_start,
    output logic [TOKW-1:0] token_length,
    output logic            last_of_run
);

    fifo_stat_t stat;
    group_t     wgroup;
    group_t     head;
    logic       push;
    logic       pop;

    stl_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .source_byte   (source_byte),
        .end_of_source (end_of_source),
        .stat          (stat),
        .push          (push),
        .group         (wgroup)
    );

    stl_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (wgroup),
        .pop   (pop),
        .rdata (head),
        .stat  (stat)
    );

    stl_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .stat         (stat),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .token_start  (token_start),
        .token_length (token_length),
        .last_of_run  (last_of_run)
    );

endmodule

// ===== rtl/stl_checker.sv =====
// ============================================================================
// stl_checker
// Port-level checks of the source text lexer, bound to the top level.
// ============================================================================
`include "source_text_lexer_top_macros.svh"

module stl_checker
    import stl_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic [7:0]      source_byte,
    input logic            end_of_source,
    input logic            out_valid,
    input logic            out_ready,
    input logic [4:0]      token_kind,
    input logic [TOKW-1:0] token_start,
    input logic [TOKW-1:0] token_length,
    input logic            last_of_run
);

    `STL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(token_kind) && $stable(token_start) && $stable(token_length) && $stable(last_of_run), "output beat changed while stalled")
    `STL_ASSERT_NOW(a_kind_range, out_valid, token_kind <= KIND_END, "token kind out of range")
    `STL_ASSERT_NOW(a_end_shape, out_valid && token_kind == KIND_END, token_length == '0 && last_of_run, "end token not closing its run or not empty")
    `STL_ASSERT_NOW(a_len_nonzero, out_valid && token_kind != KIND_END, token_length != '0, "non-end token with zero length")

endmodule

bind source_text_lexer_top stl_checker u_stl_checker (.*);
